// ===== sv/gf2pa_pkg.sv =====
package gf2pa_pkg;

    // Fixed field widths of the request and response
    localparam int W_OP  = 32;
    localparam int W_RES = 63;
    localparam int W_CMD = 2;

    // Default operand width and long-division steps folded into one stage
    localparam int OPERAND_BITS_DEF = 32;
    localparam int STEPS_PER_STAGE  = 4;

    // Command codes
    localparam logic [W_CMD-1:0] CMD_ADD = 2'd0;
    localparam logic [W_CMD-1:0] CMD_MUL = 2'd1;
    localparam logic [W_CMD-1:0] CMD_DIV = 2'd2;

    typedef struct packed {
        logic [W_CMD-1:0] cmd;
        logic [W_OP-1:0]  a_poly;
        logic [W_OP-1:0]  b_poly;
    } req_t;

    typedef struct packed {
        logic [W_RES-1:0] result_poly;
        logic [W_OP-1:0]  remainder_poly;
        logic             div_by_zero;
    } rsp_t;

    // Handshake between neighboring pipeline stages
    typedef struct packed {
        logic valid;
    } hs_t;

endpackage

// ===== sv/gf2_polynomial_alu.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_t: cmd, a_poly, b_poly
// rsp       out        rsp_valid/rsp_stall  rsp_t: result_poly, remainder_poly, div_by_zero
//
// One request enters per cycle while req_stall is low; it passes through, in order:
// an align stage, the long-division and multiply step stages (four steps each), and the
// output register. Each stage holds when the next one is full and stalled, so bubbles
// close up and nothing is dropped or repeated. Reset clears only the valid bits.
module gf2_polynomial_alu
    import gf2pa_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int N    = OPERAND_BITS;
    localparam int DW   = (N > 1) ? $clog2(N) : 1;
    localparam int NSTG = (N + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // ---------------- align stage ----------------
    logic [N-1:0]  am;
    logic [N-1:0]  bm;
    logic [DW-1:0] db_c;

    logic             s0_valid_reg;
    logic [W_CMD-1:0] s0_cmd_reg;
    logic [N-1:0]     s0_a_reg;
    logic [N-1:0]     s0_b_reg;
    logic [N-1:0]     s0_bn_reg;
    logic [DW-1:0]    s0_db_reg;
    logic             s0_ready;

    // step pipeline links; index NSTG is the output side
    hs_t              hs   [NSTG+1];
    logic             rdy  [NSTG+1];
    logic [W_CMD-1:0] cmd_w[NSTG+1];
    logic [N-1:0]     a_w  [NSTG+1];
    logic [N-1:0]     b_w  [NSTG+1];
    logic [N-1:0]     bn_w [NSTG+1];
    logic [DW-1:0]    db_w [NSTG+1];
    logic [2*N-2:0]   acc_w[NSTG+1];
    logic [N-1:0]     r_w  [NSTG+1];
    logic [N-1:0]     q_w  [NSTG+1];

    assign am = req.a_poly[N-1:0];
    assign bm = req.b_poly[N-1:0];

    // divisor degree: highest set bit
    always_comb
    begin
        db_c = '0;
        for (int i = 0; i < N; i++)
        begin
            if (bm[i])
            begin
                db_c = DW'(i);
            end
        end
    end

    assign s0_ready  = !s0_valid_reg || rdy[0];
    assign req_stall = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= req_valid;
        end
    end

    // register masked operands and the divisor shifted to the top bit
    always_ff @(posedge clk)
    begin
        if (req_valid && s0_ready)
        begin
            s0_cmd_reg <= req.cmd;
            s0_a_reg   <= am;
            s0_b_reg   <= bm;
            s0_bn_reg  <= bm << (DW'(N - 1) - db_c);
            s0_db_reg  <= db_c;
        end
    end

    assign hs[0].valid = s0_valid_reg;
    assign cmd_w[0]    = s0_cmd_reg;
    assign a_w[0]      = s0_a_reg;
    assign b_w[0]      = s0_b_reg;
    assign bn_w[0]     = s0_bn_reg;
    assign db_w[0]     = s0_db_reg;
    assign acc_w[0]    = '0;
    assign r_w[0]      = s0_a_reg;
    assign q_w[0]      = '0;

    // ---------------- step stages ----------------
    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        gf2pa_step_stage #(
            .N         (N),
            .STAGE_IDX (s),
            .DW        (DW)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up       (hs[s]),
            .up_ready (rdy[s]),
            .dn       (hs[s+1]),
            .dn_ready (rdy[s+1]),
            .cmd_in   (cmd_w[s]),
            .a_in     (a_w[s]),
            .b_in     (b_w[s]),
            .bn_in    (bn_w[s]),
            .db_in    (db_w[s]),
            .acc_in   (acc_w[s]),
            .r_in     (r_w[s]),
            .q_in     (q_w[s]),
            .cmd_out  (cmd_w[s+1]),
            .a_out    (a_w[s+1]),
            .b_out    (b_w[s+1]),
            .bn_out   (bn_w[s+1]),
            .db_out   (db_w[s+1]),
            .acc_out  (acc_w[s+1]),
            .r_out    (r_w[s+1]),
            .q_out    (q_w[s+1])
        );
    end

    // ---------------- output stage ----------------
    logic       rsp_valid_reg;
    rsp_t       rsp_reg;
    rsp_t       rsp_next;
    logic       out_ready;
    logic [N-1:0] quot;

    assign out_ready  = !rsp_valid_reg || !rsp_stall;
    assign rdy[NSTG]  = out_ready;

    // quotient bits were collected aligned to the top; drop the divisor degree
    assign quot = q_w[NSTG] >> db_w[NSTG];

    always_comb
    begin
        rsp_next = '0;
        unique case (cmd_w[NSTG])
            CMD_ADD:
            begin
                rsp_next.result_poly = W_RES'(a_w[NSTG] ^ b_w[NSTG]);
            end
            CMD_MUL:
            begin
                rsp_next.result_poly = W_RES'(acc_w[NSTG]);
            end
            CMD_DIV:
            begin
                if (b_w[NSTG] == '0)
                begin
                    rsp_next.div_by_zero = 1'b1;
                end
                else
                begin
                    rsp_next.result_poly    = W_RES'(quot);
                    rsp_next.remainder_poly = W_OP'(r_w[NSTG]);
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            rsp_valid_reg <= hs[NSTG].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hs[NSTG].valid && out_ready)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/gf2pa_step_stage.sv =====
module gf2pa_step_stage
    import gf2pa_pkg::*;
#(
    parameter int N         = OPERAND_BITS_DEF,
    parameter int STAGE_IDX = 0,
    parameter int DW        = (N > 1) ? $clog2(N) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hs_t              up,
    output logic             up_ready,
    output hs_t              dn,
    input  logic             dn_ready,
    input  logic [W_CMD-1:0] cmd_in,
    input  logic [N-1:0]     a_in,
    input  logic [N-1:0]     b_in,
    input  logic [N-1:0]     bn_in,
    input  logic [DW-1:0]    db_in,
    input  logic [2*N-2:0]   acc_in,
    input  logic [N-1:0]     r_in,
    input  logic [N-1:0]     q_in,
    output logic [W_CMD-1:0] cmd_out,
    output logic [N-1:0]     a_out,
    output logic [N-1:0]     b_out,
    output logic [N-1:0]     bn_out,
    output logic [DW-1:0]    db_out,
    output logic [2*N-2:0]   acc_out,
    output logic [N-1:0]     r_out,
    output logic [N-1:0]     q_out
);

    logic [2*N-2:0] acc_c [STEPS_PER_STAGE+1];
    logic [N-1:0]   r_c   [STEPS_PER_STAGE+1];
    logic [N-1:0]   q_c   [STEPS_PER_STAGE+1];
    logic [DW-1:0]  shift_top;

    logic             valid_reg;
    logic [W_CMD-1:0] cmd_reg;
    logic [N-1:0]     a_reg;
    logic [N-1:0]     b_reg;
    logic [N-1:0]     bn_reg;
    logic [DW-1:0]    db_reg;
    logic [2*N-2:0]   acc_reg;
    logic [N-1:0]     r_reg;
    logic [N-1:0]     q_reg;

    // last step index at which the aligned divisor still reaches the dividend
    assign shift_top = DW'(N - 1) - db_in;

    assign acc_c[0] = acc_in;
    assign r_c[0]   = r_in;
    assign q_c[0]   = q_in;

    // One multiply partial product and one division step per slice
    for (genvar j = 0; j < STEPS_PER_STAGE; j++) begin : g_step
        localparam int K = STAGE_IDX * STEPS_PER_STAGE + j;
        if (K < N) begin : g_act
            localparam logic [DW-1:0] KV   = DW'(K);
            localparam logic [N-1:0]  QBIT = N'(1) << (N - 1 - K);
            logic [2*N-2:0] a_ext;
            logic           hit;
            assign a_ext = (2*N-1)'(a_in);
            assign acc_c[j+1] = b_in[K] ? (acc_c[j] ^ (a_ext << K)) : acc_c[j];
            assign hit = (shift_top >= KV) && r_c[j][N-1-K];
            assign r_c[j+1] = hit ? (r_c[j] ^ (bn_in >> K)) : r_c[j];
            assign q_c[j+1] = hit ? (q_c[j] | QBIT) : q_c[j];
        end else begin : g_idle
            assign acc_c[j+1] = acc_c[j];
            assign r_c[j+1]   = r_c[j];
            assign q_c[j+1]   = q_c[j];
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (up.valid && up_ready)
        begin
            cmd_reg <= cmd_in;
            a_reg   <= a_in;
            b_reg   <= b_in;
            bn_reg  <= bn_in;
            db_reg  <= db_in;
            acc_reg <= acc_c[STEPS_PER_STAGE];
            r_reg   <= r_c[STEPS_PER_STAGE];
            q_reg   <= q_c[STEPS_PER_STAGE];
        end
    end

    assign dn.valid = valid_reg;
    assign cmd_out  = cmd_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign bn_out   = bn_reg;
    assign db_out   = db_reg;
    assign acc_out  = acc_reg;
    assign r_out    = r_reg;
    assign q_out    = q_reg;

endmodule
